### sv/ifbp_pkg.sv
// shared types and constants for the identifier five-bit packer
// no dependencies
package ifbp_pkg;

  localparam logic [4:0] UNDERSCORE_CODE = 5'd27;
  localparam logic [4:0] SHIFT_CODE      = 5'd28;
  localparam logic [4:0] CODE_MASK       = 5'd31;

  localparam logic [7:0] CHAR_TERM  = 8'h00;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;

  localparam logic [7:0] INDEX_MAX = 8'd255;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       bad_char;
  } result_t;

  // up to two results produced by one character
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res1;
    result_t    res0;
  } result_pair_t;

endpackage

### sv/ifbp_encoder.sv
// input register, code mapping, bit accumulator and byte counter
// depends on ifbp_pkg
module ifbp_encoder import ifbp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_char,
  input  logic         room,
  output result_pair_t pair
);

  logic       hold_r;
  logic [7:0] char_r;
  logic [6:0] store_r, store_nxt;
  logic [2:0] count_r, count_nxt;
  logic [7:0] sent_r, sent_nxt;

  logic        consume;
  logic        term, upper, lower, under, bad;
  logic [4:0]  code;
  logic [4:0]  bits5;
  logic [4:0]  code_pos;
  logic [23:0] acc;
  logic [7:0]  sent_p1, sent_p2;

  assign consume  = hold_r & room;
  assign in_ready = !hold_r | room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_ready) begin
      hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      count_r <= '0;
      sent_r  <= '0;
    end else if (consume) begin
      store_r <= store_nxt;
      count_r <= count_nxt;
      sent_r  <= sent_nxt;
    end
  end

  always_comb begin
    term  = (char_r == CHAR_TERM);
    lower = (char_r >= CHAR_LO_A) && (char_r <= CHAR_LO_Z);
    upper = (char_r >= CHAR_UP_A) && (char_r <= CHAR_UP_Z);
    under = (char_r == CHAR_UNDER);
    bad   = !(term | lower | upper | under);
    code  = 5'd0;
    if (lower) begin
      code = 5'(char_r - CHAR_LO_A) + 5'd1;
    end else if (upper) begin
      code = 5'(char_r - CHAR_UP_A) + 5'd1;
    end else if (under) begin
      code = UNDERSCORE_CODE;
    end
    code_pos = {2'b00, count_r} + (upper ? 5'd5 : 5'd0);
    bits5    = code_pos + 5'd5;
    acc      = {17'd0, store_r};
    if (upper) begin
      acc = acc | (24'(SHIFT_CODE) << count_r);
    end
    acc = acc | (24'(code & CODE_MASK) << code_pos);
  end

  assign sent_p1 = (sent_r == INDEX_MAX) ? INDEX_MAX : sent_r + 8'd1;
  assign sent_p2 = (sent_p1 == INDEX_MAX) ? INDEX_MAX : sent_p1 + 8'd1;

  always_comb begin
    pair      = '0;
    store_nxt = '0;
    count_nxt = '0;
    sent_nxt  = '0;
    pair.res0.out_byte   = acc[7:0];
    pair.res0.byte_index = sent_r;
    pair.res1.out_byte   = acc[15:8];
    pair.res1.byte_index = sent_p1;
    if (bad) begin
      pair.cnt             = 2'd1;
      pair.res0.out_byte   = 8'd0;
      pair.res0.last       = 1'b1;
      pair.res0.bad_char   = 1'b1;
    end else if (term) begin
      if (bits5 > 5'd8) begin
        pair.cnt       = 2'd2;
        pair.res1.last = 1'b1;
      end else begin
        pair.cnt       = 2'd1;
        pair.res0.last = 1'b1;
      end
    end else begin
      count_nxt = bits5[2:0];
      if (bits5 >= 5'd16) begin
        pair.cnt  = 2'd2;
        store_nxt = acc[22:16];
        sent_nxt  = sent_p2;
      end else if (bits5 >= 5'd8) begin
        pair.cnt  = 2'd1;
        store_nxt = acc[14:8];
        sent_nxt  = sent_p1;
      end else begin
        pair.cnt  = 2'd0;
        store_nxt = acc[6:0];
        sent_nxt  = sent_r;
      end
    end
    if (!consume) begin
      pair.cnt = 2'd0;
    end
  end

endmodule

### sv/ifbp_out_fifo.sv
// small result queue taking up to two words per cycle and giving one when out_ready is high
// depends on ifbp_pkg
module ifbp_out_fifo import ifbp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  result_pair_t pair,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_res
);

  result_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pop;
  logic [PTR_W-1:0]   wr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_res   = mem_r[rd_r];
  assign wr_p1     = wr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (pair.cnt != 2'd0) begin
      mem_r[wr_r] <= pair.res0;
    end
    if (pair.cnt == 2'd2) begin
      mem_r[wr_p1] <= pair.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(pair.cnt);
      rd_r  <= rd_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(pair.cnt) - CNT_W'(pop);
    end
  end

endmodule

### sv/identifier_five_bit_packer.sv
// top level of the identifier five-bit packer
// depends on ifbp_pkg, ifbp_encoder and ifbp_out_fifo
//
// Takes one identifier character per input word and packs it into 5-bit
// codes (a-z 1-26, underscore 27, uppercase as shift 28 plus the letter,
// zero byte as terminator code 0), LSB first, giving out packed bytes with
// their saturating index; the terminator flushes and marks the final byte,
// any other character gives a single error word and clears the state.
// A character is held in the input register until the queue has room,
// and its zero, one or two bytes then enter a four-word output queue
// that sends one word per cycle while out_tready is high, so the output
// port sets the pace, and a new character is taken every cycle while
// the queue has two free slots.
module identifier_five_bit_packer import ifbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte, byte_index
  output logic        out_tlast,
  output logic        out_tuser   // bad_char
);

  result_pair_t pair;
  result_t      out_res;
  logic         room;

  ifbp_encoder u_encoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .room     (room),
    .pair     (pair)
  );

  ifbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.byte_index, out_res.out_byte};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.bad_char;

endmodule

### dv/tb_identifier_five_bit_packer.sv
// self-checking bench for identifier_five_bit_packer: random and directed identifiers,
// bytes predicted from a behavioral packer and compared on the output stream
// depends on ifbp_pkg and the block rtl
`timescale 1ns / 1ps

module tb_identifier_five_bit_packer;
  import ifbp_pkg::*;

  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned LONG_LEN    = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  logic [7:0]  char_q[$];
  result_t     want_bytes[$];

  logic [6:0]  pend_bits = '0;
  int unsigned pend_cnt = 0;
  logic [7:0]  byte_pos = '0;

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  identifier_five_bit_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_byte(input logic [7:0] val, input logic is_last, input logic is_bad);
    result_t r;
    r.out_byte   = val;
    r.byte_index = byte_pos;
    r.last       = is_last;
    r.bad_char   = is_bad;
    want_bytes = {want_bytes, r};
    if (byte_pos != INDEX_MAX) byte_pos++;
  endtask

  // behavioral packer, updates its own state and queues the bytes a character gives
  task automatic pack_char(input logic [7:0] ch);
    logic [16:0] acc;
    int unsigned nbits;
    int unsigned left;
    logic [4:0]  code;
    bit          upper;
    bit          bad;
    bit          term;
    acc   = {10'd0, pend_bits};
    nbits = pend_cnt;
    code  = '0;
    upper = 1'b0;
    bad   = 1'b0;
    term  = (ch == CHAR_TERM);
    if (!term) begin
      if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
        code = 5'(ch - CHAR_LO_A + 8'd1);
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
        upper = 1'b1;
        code  = 5'(ch - CHAR_UP_A + 8'd1);
      end else if (ch == CHAR_UNDER) begin
        code = UNDERSCORE_CODE;
      end else begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      add_byte(8'd0, 1'b1, 1'b1);
      pend_bits = '0;
      pend_cnt  = 0;
      byte_pos  = '0;
    end else begin
      if (upper) begin
        acc   |= 17'(SHIFT_CODE) << nbits;
        nbits += 5;
      end
      acc   |= 17'(code & CODE_MASK) << nbits;
      nbits += 5;
      if (term) begin
        while (nbits > 0) begin
          left = (nbits > 8) ? nbits - 8 : 0;
          add_byte(acc[7:0], left == 0, 1'b0);
          acc   = acc >> 8;
          nbits = left;
        end
        pend_bits = '0;
        pend_cnt  = 0;
        byte_pos  = '0;
      end else begin
        while (nbits > 7) begin
          add_byte(acc[7:0], 1'b0, 1'b0);
          acc   = acc >> 8;
          nbits -= 8;
        end
        pend_bits = acc[6:0];
        pend_cnt  = nbits;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_char(input logic [7:0] ch);
    char_q = {char_q, ch};
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return CHAR_LO_A + 8'($urandom_range(0, 25));
    else if (r < 8) return CHAR_UP_A + 8'($urandom_range(0, 25));
    else return CHAR_UNDER;
  endfunction

  task automatic make_ident(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 24) == 0) queue_char(8'($urandom_range(1, 255)));
      else queue_char(rand_letter());
    end
    queue_char(CHAR_TERM);
  endtask

  // stimulus
  initial begin
    int unsigned k;
    bit long_done;
    long_done = 1'b0;
    char_q = '{"a", "z", "A", "Z", "_", CHAR_TERM, CHAR_TERM, "A", CHAR_TERM,
               8'h40, 8'h5b, 8'h60, 8'h7b, 8'h01, 8'hff, 8'h80,
               "Q", "b", 8'h30, "x", "y", CHAR_TERM};
    while (char_q.size() < ITEM_TARGET) begin
      if (!long_done && char_q.size() > 450) begin
        for (k = 0; k < LONG_LEN; k++) queue_char(CHAR_UP_A + 8'($urandom_range(0, 25)));
        queue_char(CHAR_TERM);
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        for (k = 0; k < $urandom_range(1, 6); k++) queue_char(8'($urandom_range(0, 255)));
      end else begin
        make_ident($urandom_range(0, 12));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || want_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (char_q.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (char_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
      gap_left = $urandom_range(0, 2);
      in_tvalid <= 1'b0;
    end else begin
      in_tdata  <= char_q[0];
      in_tvalid <= 1'b1;
    end
  end

  // output receiver with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (char_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    result_t w;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (want_bytes.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          w = want_bytes.pop_front();
          if (out_tdata[7:0] != w.out_byte)
            report_mismatch("out_byte", out_tdata[7:0], w.out_byte);
          if (out_tdata[15:8] != w.byte_index)
            report_mismatch("byte_index", out_tdata[15:8], w.byte_index);
          if (out_tlast != w.last) report_mismatch("last", out_tlast, w.last);
          if (out_tuser != w.bad_char) report_mismatch("bad_char", out_tuser, w.bad_char);
        end
      end
      if (in_tvalid && in_tready) begin
        pack_char(in_tdata);
        void'(char_q.pop_front());
        words_in++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout, no word moved for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
